/* src/rotary_position_embedding_core_defines.svh */
// Assertion macros used by the checker module.
`ifndef ROTARY_POSITION_EMBEDDING_CORE_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is held.
`define RPE_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rpe_pkg.sv */
package rpe_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Pipeline positions, counted in registers from the input register.
  localparam int PHASE_STAGE = 4;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 2;
  localparam int LANE_TAP    = PHASE_STAGE + CORDIC_LAT;
  localparam int MERGE_TAP   = LANE_TAP + 2;
  localparam int SIDE_DEPTH  = MERGE_TAP + 1;

  localparam int NUM_LANES = 4;
  localparam int LANE_QE   = 0;
  localparam int LANE_QO   = 1;
  localparam int LANE_KE   = 2;
  localparam int LANE_KO   = 3;

  localparam logic [63:0] ONE_Q31        = 64'h8000_0000;
  localparam logic [63:0] MIN_POW_Q31    = 64'd214748;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

  typedef struct packed {
    logic [15:0]        pos;
    logic signed [31:0] q_even;
    logic signed [31:0] q_odd;
    logic signed [31:0] k_even;
    logic signed [31:0] k_odd;
    logic               in_range;
    logic               krot;
  } rpe_side_t;

  function automatic logic signed [CW-1:0] atan_turns(input int i);
    logic signed [CW-1:0] v;
    unique case (i)
      0: v = 34'sd536870912;   1: v = 34'sd316933406;   2: v = 34'sd167458907;
      3: v = 34'sd85004756;    4: v = 34'sd42667331;    5: v = 34'sd21354465;
      6: v = 34'sd10679838;    7: v = 34'sd5340245;     8: v = 34'sd2670163;
      9: v = 34'sd1335087;     10: v = 34'sd667544;     11: v = 34'sd333772;
      12: v = 34'sd166886;     13: v = 34'sd83443;      14: v = 34'sd41722;
      15: v = 34'sd20861;      16: v = 34'sd10430;      17: v = 34'sd5215;
      18: v = 34'sd2608;       19: v = 34'sd1304;       20: v = 34'sd652;
      21: v = 34'sd326;        22: v = 34'sd163;        23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] pow_q31(input logic [63:0] b, input int n);
    logic [63:0] p;
    p = ONE_Q31;
    for (int i = 0; i < n; i++) begin
      p = ((p * b) >> 31) & 64'hFFFF_FFFF;
    end
    return p;
  endfunction

  // Largest Q1.31 base whose n-th power still reaches 1/10000.
  function automatic logic [63:0] freq_base(input int n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = '0;
    hi = ONE_Q31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (pow_q31(mid, n) >= MIN_POW_Q31) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  function automatic logic [31:0] freq_entry(input logic [63:0] b, input int d);
    logic [63:0] p;
    p = pow_q31(b, d);
    return 32'((p * INV_TWO_PI_Q32 + 64'h4000_0000) >> 31);
  endfunction

endpackage

/* src/rpe_cordic.sv */
module rpe_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [16:0] cos_o,
  output logic signed [16:0] sin_o
);
  import rpe_pkg::*;

  logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_r [CORDIC_STEPS+1];
  logic [1:0]           quad_r [CORDIC_STEPS+1];
  logic [31:0]          ph_rnd;
  logic [1:0]           quad_nxt;
  logic [31:0]          u_nxt;
  logic signed [18:0]   xs;
  logic signed [18:0]   ys;
  logic signed [16:0]   cc;
  logic signed [16:0]   ss;
  logic signed [16:0]   cos_r;
  logic signed [16:0]   sin_r;

  // Fold the phase to within an eighth of a turn of the nearest axis.
  assign ph_rnd   = phase + 32'h2000_0000;
  assign quad_nxt = ph_rnd[31:30];
  assign u_nxt    = phase - {quad_nxt, 30'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r[0] <= quad_nxt;
      z_r[0]    <= CW'(signed'(u_nxt));
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i+1] <= quad_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_turns(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_turns(i);
        end
      end
    end
  end

  assign xs = 19'((x_r[CORDIC_STEPS] + CW'(16384)) >>> 15);
  assign ys = 19'((y_r[CORDIC_STEPS] + CW'(16384)) >>> 15);

  always_comb begin
    if (xs > 19'sd32767) begin
      cc = 17'sd32767;
    end else if (xs < -19'sd32768) begin
      cc = -17'sd32768;
    end else begin
      cc = 17'(xs);
    end
    if (ys > 19'sd32767) begin
      ss = 17'sd32767;
    end else if (ys < -19'sd32768) begin
      ss = -17'sd32768;
    end else begin
      ss = 17'(ys);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (quad_r[CORDIC_STEPS])
        2'd0: begin cos_r <= cc;  sin_r <= ss;  end
        2'd1: begin cos_r <= -ss; sin_r <= cc;  end
        2'd2: begin cos_r <= -cc; sin_r <= -ss; end
        default: begin cos_r <= ss; sin_r <= -cc; end
      endcase
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

/* src/rpe_lane.sv */
module rpe_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [16:0] ca,
  input  logic signed [31:0] b,
  input  logic signed [16:0] cb,
  output logic signed [31:0] res,
  output logic               sat
);
  logic signed [48:0] pa_r;
  logic signed [48:0] pb_r;
  logic signed [49:0] sum;
  logic signed [34:0] sh;
  logic signed [31:0] res_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= 49'(a) * 49'(ca);
      pb_r <= 49'(b) * 49'(cb);
    end
  end

  assign sum = 50'(pa_r) + 50'(pb_r) + 50'sd16384;
  assign sh  = 35'(sum >>> 15);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sh > 35'sd2147483647) begin
        res_r <= 32'sh7FFF_FFFF;
        sat_r <= 1'b1;
      end else if (sh < -35'sd2147483648) begin
        res_r <= 32'sh8000_0000;
        sat_r <= 1'b1;
      end else begin
        res_r <= 32'(sh);
        sat_r <= 1'b0;
      end
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule

/* src/rpe_merge.sv */
module rpe_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_in,
  input  rpe_pkg::rpe_side_t side,
  input  logic signed [31:0] lane_res [rpe_pkg::NUM_LANES],
  input  logic [rpe_pkg::NUM_LANES-1:0] lane_sat,
  output logic               out_valid,
  output logic signed [31:0] q_even_rot,
  output logic signed [31:0] q_odd_rot,
  output logic signed [31:0] k_even_rot,
  output logic signed [31:0] k_odd_rot,
  output logic               key_rotated,
  output logic               saturated
);
  import rpe_pkg::*;

  logic               vld_r;
  logic signed [31:0] qe_r;
  logic signed [31:0] qo_r;
  logic signed [31:0] ke_r;
  logic signed [31:0] ko_r;
  logic               krot_r;
  logic               sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qe_r   <= side.in_range ? lane_res[LANE_QE] : side.q_even;
      qo_r   <= side.in_range ? lane_res[LANE_QO] : side.q_odd;
      ke_r   <= side.krot ? lane_res[LANE_KE] : side.k_even;
      ko_r   <= side.krot ? lane_res[LANE_KO] : side.k_odd;
      krot_r <= side.krot;
      sat_r  <= (side.in_range && (lane_sat[LANE_QE] || lane_sat[LANE_QO])) ||
                (side.krot && (lane_sat[LANE_KE] || lane_sat[LANE_KO]));
    end
  end

  assign out_valid   = vld_r;
  assign q_even_rot  = qe_r;
  assign q_odd_rot   = qo_r;
  assign k_even_rot  = ke_r;
  assign k_odd_rot   = ko_r;
  assign key_rotated = krot_r;
  assign saturated   = sat_r;

endmodule

/* src/rotary_position_embedding_core.sv */
// Rotary position embedding: each transaction carries one element pair of the query
// and of the key, the pair index and the token position, and yields one result
// transaction with both pairs rotated by position * 10000^(-d/HEAD_LEN), where d is
// twice the pair index modulo HEAD_LEN. The query pair is rotated whenever the pair
// lies inside MAX_DIM; the key pair only when twice the pair index is below kv_dim,
// otherwise it passes through and key_rotated is low. Data is Q16.16, results are
// saturated and saturated flags any clipping. The block accepts one transaction per
// clock cycle unless the pipeline is halted and holds up to 34 transactions in
// flight. It is built from the offset reduction, the frequency lookup, the phase
// multiply, the 24-step CORDIC pipeline that produces sine and cosine, the two-stage
// rotation multipliers and the output merge. The whole pipeline advances together and halts
// only while a result is waiting at the output and out_ready is low. kv_dim resets
// to 4096 and may be written through cfg_we/cfg_wdata whenever the block is idle.
module rotary_position_embedding_core #(
  parameter int HEAD_LEN = 128,
  parameter int MAX_DIM  = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [13:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_pair_index,
  input  logic [15:0]        in_position,
  input  logic signed [31:0] in_q_even,
  input  logic signed [31:0] in_q_odd,
  input  logic signed [31:0] in_k_even,
  input  logic signed [31:0] in_k_odd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_q_even_rot,
  output logic signed [31:0] out_q_odd_rot,
  output logic signed [31:0] out_k_even_rot,
  output logic signed [31:0] out_k_odd_rot,
  output logic               out_key_rotated,
  output logic               out_saturated
);
  import rpe_pkg::*;

  // Reduction of the element offset modulo HEAD_LEN by reciprocal multiplication.
  localparam int RSH   = 20;
  localparam int RECIP = (1 << RSH) / HEAD_LEN;
  localparam int IW    = (HEAD_LEN > 2) ? $clog2(HEAD_LEN) : 1;
  localparam logic [63:0] BASE = freq_base(HEAD_LEN);

  logic [13:0]          kv_dim_r;
  logic                 adv;
  logic                 vld_r [SIDE_DEPTH];
  rpe_side_t            side_r [SIDE_DEPTH];
  rpe_side_t            side_nxt;
  logic [12:0]          off_nxt;
  logic [12:0]          off_r0;
  logic [12:0]          off_r1;
  logic [32:0]          qprod_r1;
  logic [22:0]          rem_raw;
  logic [22:0]          rem_fix;
  logic [IW-1:0]        idx_r2;
  logic [31:0]          rom [HEAD_LEN];
  logic [31:0]          freq_r3;
  logic [31:0]          phase_r4;
  logic signed [16:0]   cos_w;
  logic signed [16:0]   sin_w;
  logic signed [16:0]   nsin_w;
  logic signed [31:0]   lane_a [NUM_LANES];
  logic signed [31:0]   lane_b [NUM_LANES];
  logic signed [16:0]   lane_ca [NUM_LANES];
  logic signed [16:0]   lane_cb [NUM_LANES];
  logic signed [31:0]   lane_res [NUM_LANES];
  logic [NUM_LANES-1:0] lane_sat;
  logic                 out_valid_w;

  // The frequency table is a set of constants fixed at elaboration.
  for (genvar g = 0; g < HEAD_LEN; g++) begin : g_rom
    localparam logic [31:0] FREQ = freq_entry(BASE, g);
    assign rom[g] = FREQ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_dim_r <= 14'd4096;
    end else if (cfg_we) begin
      kv_dim_r <= cfg_wdata;
    end
  end

  // The whole pipeline moves as one; it stops only for a stalled result.
  assign adv      = !out_valid_w || out_ready;
  assign in_ready = adv;

  assign off_nxt = {in_pair_index, 1'b0};

  always_comb begin
    side_nxt.pos      = in_position;
    side_nxt.q_even   = in_q_even;
    side_nxt.q_odd    = in_q_odd;
    side_nxt.k_even   = in_k_even;
    side_nxt.k_odd    = in_k_odd;
    side_nxt.in_range = 15'(off_nxt) < 15'(MAX_DIM);
    side_nxt.krot     = side_nxt.in_range && (14'(off_nxt) < kv_dim_r);
  end

  // Valid bits and the side-band shift line that keeps operands beside the maths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SIDE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // Offset modulo HEAD_LEN: the quotient estimate is at most one short.
  assign rem_raw = 23'(off_r1) - 23'(qprod_r1[32:RSH]) * 23'(HEAD_LEN);
  assign rem_fix = (rem_raw >= 23'(HEAD_LEN)) ? rem_raw - 23'(HEAD_LEN) : rem_raw;

  always_ff @(posedge clk) begin
    if (adv) begin
      off_r0   <= off_nxt;
      off_r1   <= off_r0;
      qprod_r1 <= 33'(off_r0) * 33'(RECIP);
      idx_r2   <= rem_fix[IW-1:0];
      freq_r3  <= rom[idx_r2];
      phase_r4 <= 32'(side_r[PHASE_STAGE-1].pos * freq_r3);
    end
  end

  rpe_cordic u_cordic (
    .clk   (clk),
    .en    (adv),
    .phase (phase_r4),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  assign nsin_w = -sin_w;

  // Lane operands: even' = a*cos - b*sin, odd' = a*sin + b*cos.
  always_comb begin
    lane_a[LANE_QE]  = side_r[LANE_TAP].q_even;
    lane_b[LANE_QE]  = side_r[LANE_TAP].q_odd;
    lane_ca[LANE_QE] = cos_w;
    lane_cb[LANE_QE] = nsin_w;
    lane_a[LANE_QO]  = side_r[LANE_TAP].q_even;
    lane_b[LANE_QO]  = side_r[LANE_TAP].q_odd;
    lane_ca[LANE_QO] = sin_w;
    lane_cb[LANE_QO] = cos_w;
    lane_a[LANE_KE]  = side_r[LANE_TAP].k_even;
    lane_b[LANE_KE]  = side_r[LANE_TAP].k_odd;
    lane_ca[LANE_KE] = cos_w;
    lane_cb[LANE_KE] = nsin_w;
    lane_a[LANE_KO]  = side_r[LANE_TAP].k_even;
    lane_b[LANE_KO]  = side_r[LANE_TAP].k_odd;
    lane_ca[LANE_KO] = sin_w;
    lane_cb[LANE_KO] = cos_w;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rpe_lane u_lane (
      .clk (clk),
      .en  (adv),
      .a   (lane_a[l]),
      .ca  (lane_ca[l]),
      .b   (lane_b[l]),
      .cb  (lane_cb[l]),
      .res (lane_res[l]),
      .sat (lane_sat[l])
    );
  end

  rpe_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .vld_in      (vld_r[MERGE_TAP]),
    .side        (side_r[MERGE_TAP]),
    .lane_res    (lane_res),
    .lane_sat    (lane_sat),
    .out_valid   (out_valid_w),
    .q_even_rot  (out_q_even_rot),
    .q_odd_rot   (out_q_odd_rot),
    .k_even_rot  (out_k_even_rot),
    .k_odd_rot   (out_k_odd_rot),
    .key_rotated (out_key_rotated),
    .saturated   (out_saturated)
  );

  assign out_valid = out_valid_w;

endmodule

/* src/rpe_checker.sv */
`include "rotary_position_embedding_core_defines.svh"

module rpe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_q_even_rot,
  input logic               out_key_rotated,
  input logic               out_saturated
);

  // A stalled result stays valid and keeps its even query, key_rotated and saturated flag.
  `RPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_q_even_rot) && $stable(out_key_rotated) && $stable(out_saturated), "result changed while stalled")

  // Taking a result always frees room for a new transaction.
  `RPE_ASSERT_NOW(a_ready_follows, out_ready, in_ready, "input stalled while output drains")

  // Nothing leaves the block in the cycle after reset.
  `RPE_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result valid straight after reset")

  // With the output empty the block must take transactions.
  `RPE_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind rotary_position_embedding_core rpe_checker u_rpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_q_even_rot  (out_q_even_rot),
  .out_key_rotated (out_key_rotated),
  .out_saturated   (out_saturated)
);
